@@ rtl/core/hto_pkg.sv @@
// Package for the hash table with overflow area: request and result words,
// request, status and slot mark codes, and the controller state types.
// No dependencies.
package hto_pkg;

   localparam int KEY_W     = 31;
   localparam int SLOT_W    = 5;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PRESENT   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_USED    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic              hit;
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } rsp_word_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_SUB,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_HOME,
      B_SCAN,
      B_DECIDE
   } back_state_type;

endpackage

@@ rtl/core/hto_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module hto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hto_front.sv @@
// Front end: takes a request word and works out its home slot, the key modulo
// the number of home slots, by a constant reciprocal multiply. Depends on hto_pkg.
module hto_front import hto_pkg::*; #(
   parameter int PRIME_SLOTS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  req_word_type                          req_word,
   input  logic                                  clearing,
   input  q_status_type                          q_status,
   output logic                                  busy,
   output logic                                  push,
   output logic [$clog2(PRIME_SLOTS)+KEY_W+1:0]  push_data
);

   localparam int HW    = $clog2(PRIME_SLOTS);
   localparam int MW    = KEY_W + 1;
   localparam int PW    = KEY_W + MW;
   localparam int SHIFT = KEY_W + HW;
   localparam logic [63:0] RECIP_NUM = 64'd1 << SHIFT;
   // Rounded-up reciprocal; exact quotients for every key of KEY_W bits.
   localparam logic [MW-1:0] RECIP =
      MW'((RECIP_NUM + 64'(PRIME_SLOTS) - 64'd1) / 64'(PRIME_SLOTS));
   localparam logic [HW-1:0] P_LOW = HW'(PRIME_SLOTS);

   front_state_type  state_ff, state_in;
   req_word_type     req_ff, req_in;
   logic [HW-1:0]    quot_ff, quot_in;
   logic [HW-1:0]    rem_ff, rem_in;
   logic [PW-1:0]    product;

   assign product = PW'(req_ff.key) * PW'(RECIP);

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start && !clearing) begin
               req_in   = req_word;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // Only the low bits of the quotient matter for the remainder.
            quot_in  = product[SHIFT +: HW];
            state_in = F_SUB;
         end
         F_SUB: begin
            rem_in   = req_ff.key[HW-1:0] - quot_ff * P_LOW;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff  <= req_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy      = (state_ff != F_IDLE) || clearing;
   assign push_data = {rem_ff, req_ff};

endmodule

@@ rtl/core/hto_queue.sv @@
// Two-word queue between the front end and the table controller.
// Depends on hto_pkg.
module hto_queue import hto_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output q_status_type     q_status
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data      = data_ff[rd_ptr_ff];
   assign q_status.empty = (cnt_ff == 2'd0);
   assign q_status.full  = (cnt_ff == 2'd2);

endmodule

@@ rtl/core/hto_back.sv @@
// Table controller: clears the slot marks after reset, then carries out queued
// requests against the key and mark RAMs. Depends on hto_pkg and hto_ram.
module hto_back import hto_pkg::*; #(
   parameter int PRIME_SLOTS    = 16,
   parameter int OVERFLOW_SLOTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(PRIME_SLOTS)+KEY_W+1:0] head_data,
   input  q_status_type                         q_status,
   output logic                                 pop,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   output rsp_word_type                         rsp_word
);

   localparam int HW    = $clog2(PRIME_SLOTS);
   localparam int TOTAL = PRIME_SLOTS + OVERFLOW_SLOTS;
   localparam int AW    = $clog2(TOTAL);
   localparam int UW    = $clog2(OVERFLOW_SLOTS + 1);
   localparam int REQ_W = $bits(req_word_type);

   back_state_type state_ff, state_in;
   req_word_type   item_ff, item_in;
   logic [HW-1:0]  home_ff, home_in;
   logic           found_ff, found_in;
   logic           found_home_ff, found_home_in;
   logic [AW-1:0]  where_ff, where_in;
   logic [1:0]     home_mark_ff, home_mark_in;
   logic [UW-1:0]  idx_ff, idx_in;
   logic [UW-1:0]  used_ff, used_in;
   logic [HW-1:0]  clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic             key_wr_en, key_rd_en;
   logic [AW-1:0]    key_wr_addr, key_rd_addr;
   logic [KEY_W-1:0] key_wr_data, key_rd_data;
   logic             mark_wr_en, mark_rd_en;
   logic [HW-1:0]    mark_wr_addr, mark_rd_addr;
   logic [1:0]       mark_wr_data, mark_rd_data;

   req_word_type  head_req;
   logic [HW-1:0] head_home;
   logic [UW-1:0] idx_plus;
   logic [AW-1:0] ovf_addr;

   assign head_req  = req_word_type'(head_data[REQ_W-1:0]);
   assign head_home = head_data[REQ_W+HW-1:REQ_W];
   assign idx_plus  = idx_ff + UW'(1);
   assign ovf_addr  = AW'(PRIME_SLOTS) + AW'(used_ff);

   hto_ram #(.WIDTH(KEY_W), .DEPTH(TOTAL)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   hto_ram #(.WIDTH(2), .DEPTH(PRIME_SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      home_in       = home_ff;
      found_in      = found_ff;
      found_home_in = found_home_ff;
      where_in      = where_ff;
      home_mark_in  = home_mark_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = rsp_word_ff;
      pop           = 1'b0;
      key_wr_en     = 1'b0;
      key_wr_addr   = ovf_addr;
      key_wr_data   = item_ff.key;
      key_rd_en     = 1'b0;
      key_rd_addr   = AW'(PRIME_SLOTS) + AW'(idx_ff);
      mark_wr_en    = 1'b0;
      mark_wr_addr  = home_ff;
      mark_wr_data  = MARK_USED;
      mark_rd_en    = 1'b0;
      mark_rd_addr  = head_home;
      case (state_ff)
         B_CLEAR: begin
            mark_wr_en   = 1'b1;
            mark_wr_addr = clr_ff;
            mark_wr_data = MARK_EMPTY;
            clr_in       = clr_ff + HW'(1);
            if (clr_ff == HW'(PRIME_SLOTS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_status.empty) begin
               pop           = 1'b1;
               item_in       = head_req;
               home_in       = head_home;
               found_in      = 1'b0;
               found_home_in = 1'b0;
               where_in      = '0;
               key_rd_en     = 1'b1;
               key_rd_addr   = AW'(head_home);
               mark_rd_en    = 1'b1;
               state_in      = B_HOME;
            end
         end
         B_HOME: begin
            home_mark_in = mark_rd_data;
            if (mark_rd_data == MARK_USED && key_rd_data == item_ff.key) begin
               found_in      = 1'b1;
               found_home_in = 1'b1;
               where_in      = AW'(home_ff);
               state_in      = B_DECIDE;
            end else if (used_ff == '0) begin
               state_in = B_DECIDE;
            end else begin
               idx_in      = '0;
               key_rd_en   = 1'b1;
               key_rd_addr = AW'(PRIME_SLOTS);
               state_in    = B_SCAN;
            end
         end
         B_SCAN: begin
            // Every overflow entry below the fill count holds a live key.
            if (key_rd_data == item_ff.key) begin
               found_in = 1'b1;
               where_in = AW'(PRIME_SLOTS) + AW'(idx_ff);
               state_in = B_DECIDE;
            end else if (idx_plus == used_ff) begin
               state_in = B_DECIDE;
            end else begin
               idx_in      = idx_plus;
               key_rd_en   = 1'b1;
               key_rd_addr = AW'(PRIME_SLOTS) + AW'(idx_plus);
            end
         end
         B_DECIDE: begin
            rsp_valid_in       = 1'b1;
            rsp_word_in.hit    = found_ff;
            rsp_word_in.status = ST_NOT_FOUND;
            rsp_word_in.slot   = '0;
            case (item_ff.req_type)
               REQ_INSERT: begin
                  if (found_ff) begin
                     rsp_word_in.status = ST_PRESENT;
                     rsp_word_in.slot   = SLOT_W'(where_ff);
                  end else if (home_mark_ff == MARK_EMPTY) begin
                     key_wr_en          = 1'b1;
                     key_wr_addr        = AW'(home_ff);
                     mark_wr_en         = 1'b1;
                     rsp_word_in.status = ST_DONE;
                     rsp_word_in.slot   = SLOT_W'(home_ff);
                  end else if (used_ff < UW'(OVERFLOW_SLOTS)) begin
                     key_wr_en          = 1'b1;
                     used_in            = used_ff + UW'(1);
                     rsp_word_in.status = ST_DONE;
                     rsp_word_in.slot   = SLOT_W'(ovf_addr);
                  end else begin
                     rsp_word_in.status = ST_FULL;
                  end
               end
               REQ_DELETE: begin
                  if (found_home_ff) begin
                     mark_wr_en         = 1'b1;
                     mark_wr_data       = MARK_DELETED;
                     rsp_word_in.status = ST_DONE;
                     rsp_word_in.slot   = SLOT_W'(home_ff);
                  end else if (found_ff) begin
                     rsp_word_in.slot = SLOT_W'(where_ff);
                  end
               end
               default: begin
                  // Lookup, and the unused request code handled as one.
                  if (found_ff) begin
                     rsp_word_in.status = ST_DONE;
                     rsp_word_in.slot   = SLOT_W'(where_ff);
                  end
               end
            endcase
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      home_ff       <= home_in;
      found_ff      <= found_in;
      found_home_ff <= found_home_in;
      where_ff      <= where_in;
      home_mark_ff  <= home_mark_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/core/hash_table_with_overflow_area_unit.sv @@
// Top level of the hash table with overflow area: front end, queue and table
// controller. Depends on hto_pkg, hto_front, hto_queue and hto_back.

// A keyed set in a hash table of PRIME_SLOTS home slots and an overflow area of
// OVERFLOW_SLOTS entries. A request word is taken when start is high and busy is
// low; each request gives exactly one result word, shown for one cycle with
// rsp_valid high, and the receiver cannot hold it off. After reset the block
// clears its slot marks, one per cycle, and stays busy until all are cleared.
// The front end finds the home slot with a multiply by a constant reciprocal,
// through its multiply, subtract and push states, and can take the next word while
// the controller works; it waits in its push state while the queue is full. The
// controller reads the home slot, then, unless the home slot holds the key, compares
// overflow entries one by one, up to the number in use, and then decides; a two-word
// queue lies between the two parts.
module hash_table_with_overflow_area_unit import hto_pkg::*; #(
   parameter int PRIME_SLOTS    = 16,
   parameter int OVERFLOW_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int QW = $clog2(PRIME_SLOTS) + KEY_W + 2;

   q_status_type  q_status;
   logic          push, pop, clearing;
   logic [QW-1:0] push_data, head_data;

   hto_front #(.PRIME_SLOTS(PRIME_SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .clearing  (clearing),
      .q_status  (q_status),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   hto_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   hto_back #(
      .PRIME_SLOTS    (PRIME_SLOTS),
      .OVERFLOW_SLOTS (OVERFLOW_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_status  (q_status),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   // Result words never come back to back.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result words on consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_FULL) |-> (!rsp_word.hit && rsp_word.slot == '0))
      else $error("full result with a hit or a slot");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_PRESENT) |-> rsp_word.hit)
      else $error("already-present result without a hit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.hit && rsp_word.status == ST_NOT_FOUND)
         |-> (rsp_word.slot == '0))
      else $error("miss reports a slot");

   // While the marks are being cleared no request may be taken.
   assert property (@(posedge clock) disable iff (reset) clearing |-> busy)
      else $error("request port open during the clearing pass");
`endif

endmodule

@@ tb/tb_hash_table_with_overflow_area_unit.sv @@
// Testbench for hash_table_with_overflow_area_unit: a directed table, then random
// lookups, inserts and deletes, each result checked against a behavioural table
// or the answer its directed row gives. Depends on hto_pkg and the block's RTL.
module tb_hash_table_with_overflow_area_unit;
   import hto_pkg::*;

   localparam int PRIME_SLOTS    = 16;
   localparam int OVERFLOW_SLOTS = 8;
   localparam int TOTAL_SLOTS    = PRIME_SLOTS + OVERFLOW_SLOTS;
   localparam int RANDOM_ITEMS   = 750;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 2 * (OVERFLOW_SLOTS + 3) + 20;
   localparam int ROW_COUNT      = 24;

   // The unused request code is served as a lookup.
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [KEY_W-1:0]  key;
      logic              typed;
      logic              hit;
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   // Shadow copy of the table.
   logic [KEY_W-1:0] shadow_key [TOTAL_SLOTS];
   logic [1:0]       shadow_mark [TOTAL_SLOTS];
   int               shadow_spill;

   rsp_word_type expected_results [$];
   logic             row_typed;
   rsp_word_type     row_expected;
   logic [KEY_W-1:0] key_pool [32];

   int error_count;
   int cycle_count;
   int result_count;
   int hit_count;
   int full_count;
   int sent_count;
   int burst_left;

   stim_row_type directed_rows [0:ROW_COUNT-1] = '{
      '{REQ_LOOKUP, 31'd1,          1'b1, 1'b0, ST_NOT_FOUND, 5'd0},
      '{REQ_DELETE, 31'd5,          1'b1, 1'b0, ST_NOT_FOUND, 5'd0},
      '{REQ_INSERT, 31'd0,          1'b1, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'h7FFFFFFF,   1'b1, 1'b0, ST_DONE,      5'd15},
      '{REQ_LOOKUP, 31'h7FFFFFFF,   1'b1, 1'b1, ST_DONE,      5'd15},
      '{REQ_SPARE,  31'd0,          1'b1, 1'b1, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd0,          1'b1, 1'b1, ST_PRESENT,   5'd0},
      '{REQ_INSERT, 31'd16,         1'b1, 1'b0, ST_DONE,      5'd16},
      '{REQ_DELETE, 31'd16,         1'b1, 1'b1, ST_NOT_FOUND, 5'd16},
      '{REQ_DELETE, 31'd0,          1'b1, 1'b1, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd32,         1'b1, 1'b0, ST_DONE,      5'd17},
      '{REQ_LOOKUP, 31'd0,          1'b1, 1'b0, ST_NOT_FOUND, 5'd0},
      '{REQ_INSERT, 31'd0,          1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd48,         1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd64,         1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd80,         1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd96,         1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd112,        1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'd128,        1'b1, 1'b0, ST_FULL,      5'd0},
      '{REQ_LOOKUP, 31'd112,        1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_INSERT, 31'h2AAAAAAA,   1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_LOOKUP, 31'h55555555,   1'b0, 1'b0, ST_DONE,      5'd0},
      '{REQ_DELETE, 31'h7FFFFFFF,   1'b1, 1'b1, ST_DONE,      5'd15},
      '{REQ_LOOKUP, 31'h7FFFFFFF,   1'b1, 1'b0, ST_NOT_FOUND, 5'd0}
   };

   hash_table_with_overflow_area_unit #(
      .PRIME_SLOTS    (PRIME_SLOTS),
      .OVERFLOW_SLOTS (OVERFLOW_SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Applies one request word to the shadow table and returns the result it gives.
   function automatic rsp_word_type apply_request(req_word_type w);
      int           home;
      int           found_at;
      bit           present;
      rsp_word_type r;
      home     = int'(w.key % PRIME_SLOTS);
      found_at = 0;
      present  = 1'b0;
      if (shadow_mark[home] == MARK_USED && shadow_key[home] == w.key) begin
         present  = 1'b1;
         found_at = home;
      end else begin
         for (int i = 0; i < shadow_spill && !present; i++) begin
            if (shadow_mark[PRIME_SLOTS+i] == MARK_USED &&
                shadow_key[PRIME_SLOTS+i] == w.key) begin
               present  = 1'b1;
               found_at = PRIME_SLOTS + i;
            end
         end
      end
      r.hit  = present;
      r.slot = '0;
      case (w.req_type)
         REQ_INSERT: begin
            if (present) begin
               r.status = ST_PRESENT;
               r.slot   = SLOT_W'(found_at);
            end else if (shadow_mark[home] == MARK_EMPTY) begin
               shadow_key[home]  = w.key;
               shadow_mark[home] = MARK_USED;
               r.status = ST_DONE;
               r.slot   = SLOT_W'(home);
            end else if (shadow_spill < OVERFLOW_SLOTS) begin
               shadow_key[PRIME_SLOTS+shadow_spill]  = w.key;
               shadow_mark[PRIME_SLOTS+shadow_spill] = MARK_USED;
               r.status = ST_DONE;
               r.slot   = SLOT_W'(PRIME_SLOTS + shadow_spill);
               shadow_spill++;
            end else begin
               r.status = ST_FULL;
            end
         end
         REQ_DELETE: begin
            // Only a home slot entry is removed; an overflow entry stays put.
            if (present && found_at == home) begin
               shadow_mark[home] = MARK_DELETED;
               r.status = ST_DONE;
               r.slot   = SLOT_W'(home);
            end else begin
               r.status = ST_NOT_FOUND;
               if (present) r.slot = SLOT_W'(found_at);
            end
         end
         default: begin
            r.status = present ? ST_DONE : ST_NOT_FOUND;
            if (present) r.slot = SLOT_W'(found_at);
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch at result %0d: %s is %0d, expected %0d",
               result_count, field, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic [1:0] kind, input logic [KEY_W-1:0] key);
      start    <= 1'b1;
      req_word <= '{req_type: kind, key: key};
      do @(posedge clock); while (busy);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   always @(posedge clock) begin : monitor
      rsp_word_type predicted;
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("result word with nothing expected: %p", rsp_word);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_word.hit !== want.hit)
                  report_mismatch("hit", rsp_word.hit, want.hit);
               if (rsp_word.status !== want.status)
                  report_mismatch("status", rsp_word.status, want.status);
               if (rsp_word.slot !== want.slot)
                  report_mismatch("slot", rsp_word.slot, want.slot);
               if (want.hit) hit_count++;
               if (want.status == ST_FULL) full_count++;
            end
            result_count++;
         end
         // The shadow table is always updated, even where the row gives its own answer.
         if (start && !busy) begin
            predicted = apply_request(req_word);
            expected_results.push_back(row_typed ? row_expected : predicted);
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at cycle %0d with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("** hash_table_with_overflow_area_unit: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int               pick;
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      row_typed    = 1'b0;
      row_expected = '0;
      error_count  = 0;
      cycle_count  = 0;
      result_count = 0;
      hit_count    = 0;
      full_count   = 0;
      sent_count   = 0;
      burst_left   = 0;
      shadow_spill = 0;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         shadow_key[i]  = '0;
         shadow_mark[i] = MARK_EMPTY;
      end
      for (int i = 0; i < 32; i++)
         key_pool[i] = (i < 16) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom());
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++) begin
         pace_sender();
         row_typed    = directed_rows[r].typed;
         row_expected = '{hit: directed_rows[r].hit, status: directed_rows[r].status,
                          slot: directed_rows[r].slot};
         send_word(directed_rows[r].kind, directed_rows[r].key);
      end

      row_typed = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      kind = REQ_LOOKUP;
         else if (pick < 70) kind = REQ_INSERT;
         else if (pick < 95) kind = REQ_DELETE;
         else                kind = REQ_SPARE;
         // Known keys give hits and deletes that land; small keys pile onto few homes.
         pick = $urandom_range(0, 99);
         if (pick < 55)      key = key_pool[$urandom_range(0, 31)];
         else if (pick < 75) key = KEY_W'($urandom_range(0, 63));
         else                key = KEY_W'($urandom());
         if (kind == REQ_INSERT) key_pool[$urandom_range(0, 31)] = key;
         pace_sender();
         send_word(kind, key);
      end
      start <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words sent, %0d result words checked, %0d errors",
               sent_count, result_count, error_count);
      $display("%0d results were hits and %0d reported the overflow area full",
               hit_count, full_count);
      if (error_count == 0)
         $display("** hash_table_with_overflow_area_unit: PASSED **");
      else
         $display("** hash_table_with_overflow_area_unit: FAILED **");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/hto_pkg.sv
rtl/core/hto_ram.sv
rtl/core/hto_front.sv
rtl/core/hto_queue.sv
rtl/core/hto_back.sv
rtl/core/hash_table_with_overflow_area_unit.sv
tb/tb_hash_table_with_overflow_area_unit.sv
